// ===== sv/twf_pkg.sv =====
// shared constants, types and the sine table builder of the tape wow/flutter delay
package twf_pkg;

   localparam int DELAY_DEPTH  = 4096;
   localparam int CHANNELS     = 2;
   localparam int SINE_ENTRIES = 1024;

   localparam int IDX_W     = $clog2(DELAY_DEPTH);
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MEM_AW    = IDX_W + CH_W;
   localparam int MEM_DEPTH = CHANNELS * DELAY_DEPTH;
   localparam int SINE_AW   = $clog2(SINE_ENTRIES);
   localparam int FRAC_W    = 16;
   localparam int POS_W     = IDX_W + FRAC_W;
   localparam int DSUM_W    = (POS_W + 1 > 30) ? POS_W + 1 : 30;
   localparam int SAMPLE_W  = 24;
   localparam int TONE_W    = 32;
   localparam int CHIN_W    = 4;
   localparam int CNT_W     = 5;
   localparam int BASE_W    = 28;
   localparam int DEPTH_W   = 27;
   localparam int PHASE_W   = 32;
   localparam int COEFF_W   = 16;
   localparam int SINE_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [POS_W-1:0] DLY_MIN = POS_W'(64'd1 << FRAC_W);
   localparam logic [POS_W-1:0] DLY_MAX = POS_W'(64'(DELAY_DEPTH - 2) << FRAC_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNELS   = 3'd0,
      CSR_BASE       = 3'd1,
      CSR_WOW_DEPTH  = 3'd2,
      CSR_FLUT_DEPTH = 3'd3,
      CSR_WOW_STEP   = 3'd4,
      CSR_FLUT_STEP  = 3'd5,
      CSR_TONE       = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0]   channels_in_use;
      logic [BASE_W-1:0]  base_delay;
      logic [DEPTH_W-1:0] wow_depth;
      logic [DEPTH_W-1:0] flutter_depth;
      logic [PHASE_W-1:0] wow_step;
      logic [PHASE_W-1:0] flutter_step;
      logic [COEFF_W-1:0] tone_coeff;
   } cfg_type;

   typedef struct packed {
      logic                       we;
      logic [MEM_AW-1:0]          waddr;
      logic signed [SAMPLE_W-1:0] wdata;
      logic [MEM_AW-1:0]          raddr;
   } ram_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_POS, ST_RD0, ST_RD1,
      ST_INTERP, ST_MIX, ST_TONE, ST_DONE
   } state_type;

   typedef logic signed [SINE_W-1:0] sine_tab_type [SINE_ENTRIES];

   // channel count clamped to [1, CHANNELS]
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] r;
      r = n;
      if (n == '0) r = CNT_W'(1);
      if (n > CNT_W'(CHANNELS)) r = CNT_W'(CHANNELS);
      return r;
   endfunction

   // sin(pi/2 * t), Q30 in and out
   function automatic logic [63:0] quarter_sine(input logic [63:0] t);
      logic [63:0] t2;
      logic [63:0] a;
      t2 = (t * t) >> 30;
      a  = 64'd3864;
      a  = 64'd172272 - ((t2 * a) >> 30);
      a  = 64'd5026995 - ((t2 * a) >> 30);
      a  = 64'd85569306 - ((t2 * a) >> 30);
      a  = 64'd693598669 - ((t2 * a) >> 30);
      a  = 64'd1686629713 - ((t2 * a) >> 30);
      return (t * a) >> 30;
   endfunction

   function automatic sine_tab_type build_sine();
      sine_tab_type tab;
      logic [63:0]  p;
      logic [63:0]  quad;
      logic [63:0]  t;
      logic [63:0]  v;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         p    = 64'(k) * 64'd4;
         quad = p / SINE_ENTRIES;
         t    = ((p % SINE_ENTRIES) << 30) / SINE_ENTRIES;
         if (quad[0]) t = (64'd1 << 30) - t;
         v = (quarter_sine(t) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) v = 64'd32767;
         tab[k] = (quad >= 64'd2) ? -$signed(SINE_W'(v)) : $signed(SINE_W'(v));
      end
      return tab;
   endfunction

endpackage

// ===== sv/twf_ifs.sv =====
// channel interfaces: sample request, result and register write
interface twf_req_if import twf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CHIN_W-1:0]          channel;
   logic signed [SAMPLE_W-1:0] sample_in;
   modport source (output valid, channel, sample_in, input ready);
   modport sink (input valid, channel, sample_in, output ready);
endinterface

interface twf_rsp_if import twf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CHIN_W-1:0]          channel_out;
   logic signed [SAMPLE_W-1:0] sample_out;
   modport source (output valid, channel_out, sample_out, input ready);
   modport sink (input valid, channel_out, sample_out, output ready);
endinterface

interface twf_csr_if import twf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/twf_csr.sv =====
// configuration register file
module twf_csr import twf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   twf_csr_if.sink   csr_bus,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_CHANNELS:   cfg_in.channels_in_use = csr_bus.data[CNT_W-1:0];
            CSR_BASE:       cfg_in.base_delay      = csr_bus.data[BASE_W-1:0];
            CSR_WOW_DEPTH:  cfg_in.wow_depth       = csr_bus.data[DEPTH_W-1:0];
            CSR_FLUT_DEPTH: cfg_in.flutter_depth   = csr_bus.data[DEPTH_W-1:0];
            CSR_WOW_STEP:   cfg_in.wow_step        = csr_bus.data[PHASE_W-1:0];
            CSR_FLUT_STEP:  cfg_in.flutter_step    = csr_bus.data[PHASE_W-1:0];
            CSR_TONE:       cfg_in.tone_coeff      = csr_bus.data[COEFF_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channels_in_use <= CNT_W'(2);
         cfg_ff.base_delay      <= BASE_W'(1048576);
         cfg_ff.wow_depth       <= '0;
         cfg_ff.flutter_depth   <= '0;
         cfg_ff.wow_step        <= '0;
         cfg_ff.flutter_step    <= '0;
         cfg_ff.tone_coeff      <= COEFF_W'(65535);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/twf_sine_rom.sv =====
// dual-read sine table, registered outputs
module twf_sine_rom import twf_pkg::*; (
   input  logic                     clock,
   input  logic [SINE_AW-1:0]       addr_a,
   input  logic [SINE_AW-1:0]       addr_b,
   output logic signed [SINE_W-1:0] data_a,
   output logic signed [SINE_W-1:0] data_b
);

   localparam sine_tab_type SINE_TAB = build_sine();

   logic signed [SINE_W-1:0] data_a_ff;
   logic signed [SINE_W-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      data_a_ff <= SINE_TAB[addr_a];
      data_b_ff <= SINE_TAB[addr_b];
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

// ===== sv/twf_delay_ram.sv =====
// delay line memory, all channels, with clearing sweep after reset
module twf_delay_ram import twf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  ram_ctl_type                ctl,
   output logic signed [SAMPLE_W-1:0] rd_data,
   output logic                       clr_busy
);

   logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       clr_busy_ff;
   logic                       clr_busy_in;
   logic [MEM_AW-1:0]          clr_addr_ff;
   logic [MEM_AW-1:0]          clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == MEM_AW'(MEM_DEPTH - 1)) clr_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rd_data_ff <= mem[ctl.raddr];
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// ===== sv/tape_wow_flutter_delay_unit.sv =====
// tape wow/flutter delay: modulated fractional delay line and one-pole lowpass
//
//   channel   dir   beat fields
//   req_bus   in    channel, sample_in
//   rsp_bus   out   channel_out, sample_out
//   csr_bus   in    index, data
//
// one sample at a time, req ready only while idle: the delay memory has one read
// port, so the two neighbour reads go in turn, followed by two chained multiplies
// a sample of a channel outside the frame skips to the final step and returns zero
// after reset the delay memory is swept to zero, with req ready low
// a stalled result waits in the output register; the engine holds in its last step
module tape_wow_flutter_delay_unit import twf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   twf_req_if.sink    req_bus,
   twf_rsp_if.source  rsp_bus,
   twf_csr_if.sink    csr_bus
);

   cfg_type                    cfg;
   ram_ctl_type                ram_ctl;
   logic signed [SAMPLE_W-1:0] ram_rd;
   logic                       clr_busy;
   logic signed [SINE_W-1:0]   sin_w;
   logic signed [SINE_W-1:0]   sin_f;

   state_type                  state_ff, state_in;
   logic [CHIN_W-1:0]          ch_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       skip_ff;
   logic [IDX_W-1:0]           w_ff;
   logic [PHASE_W-1:0]         wow_phase_ff;
   logic [PHASE_W-1:0]         flut_phase_ff;
   logic [DEPTH_W-1:0]         mag_w_ff, mag_f_ff;
   logic                       neg_w_ff, neg_f_ff;
   logic [POS_W-1:0]           delay_ff;
   logic [POS_W-1:0]           rp_ff;
   logic signed [SAMPLE_W-1:0] d0_ff;
   logic signed [SAMPLE_W+FRAC_W+1:0] ip_ff;
   logic signed [TONE_W:0]     diff_ff;
   logic signed [TONE_W+COEFF_W+1:0]  tp_ff;
   logic signed [TONE_W-1:0]   tone_st_ff [CHANNELS];
   logic                       rsp_valid_ff;
   logic [CHIN_W-1:0]          rsp_ch_ff;
   logic signed [SAMPLE_W-1:0] rsp_smp_ff;

   logic [CNT_W-1:0]           cnt;
   logic                       req_fire;
   logic                       rsp_free;
   logic                       done_fire;
   logic                       frame_end;
   logic [SINE_W-2:0]          abs_w, abs_f;
   logic signed [DSUM_W-1:0]   term_w, term_f, dsum;
   logic [POS_W-1:0]           delay_sat;
   logic [IDX_W-1:0]           i0;
   logic signed [SAMPLE_W:0]   dd;
   logic signed [SAMPLE_W+1:0] y;
   logic signed [TONE_W-1:0]   st_cur;
   logic signed [TONE_W-1:0]   st_new;
   logic signed [TONE_W-1:0]   y_q8;

   twf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   twf_sine_rom u_sine (
      .clock  (clock),
      .addr_a (wow_phase_ff[PHASE_W-1 -: SINE_AW]),
      .addr_b (flut_phase_ff[PHASE_W-1 -: SINE_AW]),
      .data_a (sin_w),
      .data_b (sin_f)
   );

   twf_delay_ram u_ram (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ram_ctl),
      .rd_data  (ram_rd),
      .clr_busy (clr_busy)
   );

   assign cnt       = eff_count(cfg.channels_in_use);
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;
   assign frame_end = ({1'b0, ch_ff} == cnt - 1'b1);
   assign i0        = rp_ff[POS_W-1:FRAC_W];
   assign st_cur    = tone_st_ff[ch_ff[CH_W-1:0]];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ({1'b0, req_bus.channel} >= cnt) ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL:    state_in = ST_SUM;
         ST_SUM:    state_in = ST_POS;
         ST_POS:    state_in = ST_RD0;
         ST_RD0:    state_in = ST_RD1;
         ST_RD1:    state_in = ST_INTERP;
         ST_INTERP: state_in = ST_MIX;
         ST_MIX:    state_in = ST_TONE;
         ST_TONE:   state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_bus.ready = 1'b0;
      done_fire     = 1'b0;
      ram_ctl.we    = 1'b0;
      ram_ctl.waddr = {ch_ff[CH_W-1:0], w_ff};
      ram_ctl.wdata = x_ff;
      ram_ctl.raddr = {ch_ff[CH_W-1:0], i0};
      case (state_ff)
         ST_IDLE: req_bus.ready = !clr_busy;
         ST_MUL:  ram_ctl.we = 1'b1;
         ST_RD1:  ram_ctl.raddr = {ch_ff[CH_W-1:0], i0 + 1'b1};
         ST_DONE: done_fire = rsp_free;
         default: req_bus.ready = 1'b0;
      endcase
   end

   // datapath arithmetic
   always_comb begin
      abs_w  = sin_w[SINE_W-1] ? (SINE_W-1)'(-sin_w) : sin_w[SINE_W-2:0];
      abs_f  = sin_f[SINE_W-1] ? (SINE_W-1)'(-sin_f) : sin_f[SINE_W-2:0];
      term_w = $signed(DSUM_W'(mag_w_ff));
      term_f = $signed(DSUM_W'(mag_f_ff));
      if (neg_w_ff) term_w = -term_w;
      if (neg_f_ff) term_f = -term_f;
      dsum = $signed(DSUM_W'(cfg.base_delay)) + term_w + term_f;
      if (dsum < $signed(DSUM_W'(DLY_MIN))) begin
         delay_sat = DLY_MIN;
      end else if (dsum > $signed(DSUM_W'(DLY_MAX))) begin
         delay_sat = DLY_MAX;
      end else begin
         delay_sat = dsum[POS_W-1:0];
      end
      dd     = {ram_rd[SAMPLE_W-1], ram_rd} - {d0_ff[SAMPLE_W-1], d0_ff};
      y      = {{2{d0_ff[SAMPLE_W-1]}}, d0_ff} + ip_ff[FRAC_W +: SAMPLE_W+2];
      y_q8   = {y[SAMPLE_W-1:0], 8'h00};
      st_new = st_cur + tp_ff[FRAC_W +: TONE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         w_ff          <= '0;
         wow_phase_ff  <= '0;
         flut_phase_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) tone_st_ff[c] <= '0;
      end else begin
         state_ff <= state_in;
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
            if (!skip_ff) begin
               tone_st_ff[ch_ff[CH_W-1:0]] <= st_new;
               if (frame_end) begin
                  wow_phase_ff  <= wow_phase_ff + cfg.wow_step;
                  flut_phase_ff <= flut_phase_ff + cfg.flutter_step;
                  w_ff          <= w_ff + 1'b1;
               end
            end
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff   <= req_bus.channel;
         x_ff    <= req_bus.sample_in;
         skip_ff <= ({1'b0, req_bus.channel} >= cnt);
      end
      if (state_ff == ST_MUL) begin
         mag_w_ff <= DEPTH_W'(((DEPTH_W+SINE_W-1)'(cfg.wow_depth)
                              * (DEPTH_W+SINE_W-1)'(abs_w)) >> 15);
         mag_f_ff <= DEPTH_W'(((DEPTH_W+SINE_W-1)'(cfg.flutter_depth)
                              * (DEPTH_W+SINE_W-1)'(abs_f)) >> 15);
         neg_w_ff <= sin_w[SINE_W-1];
         neg_f_ff <= sin_f[SINE_W-1];
      end
      if (state_ff == ST_SUM) delay_ff <= delay_sat;
      // wraps modulo the line length
      if (state_ff == ST_POS) rp_ff <= {w_ff, FRAC_W'(0)} - delay_ff;
      if (state_ff == ST_RD1) d0_ff <= ram_rd;
      if (state_ff == ST_INTERP) ip_ff <= dd * $signed({1'b0, rp_ff[FRAC_W-1:0]});
      if (state_ff == ST_MIX) diff_ff <= {y_q8[TONE_W-1], y_q8} - {st_cur[TONE_W-1], st_cur};
      if (state_ff == ST_TONE) tp_ff <= diff_ff * $signed({1'b0, cfg.tone_coeff});
      if (done_fire) begin
         rsp_ch_ff  <= ch_ff;
         rsp_smp_ff <= skip_ff ? '0 : st_new[TONE_W-1:8];
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.channel_out = rsp_ch_ff;
   assign rsp_bus.sample_out  = rsp_smp_ff;

`ifndef ASSERT_OFF
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final step");

   a_phase_frame_end: assert property (@(posedge clock) disable iff (reset)
      !$stable(wow_phase_ff) |-> $past(done_fire && frame_end && !skip_ff))
      else $error("wow phase moved outside a frame end");

   a_neighbour_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD1) |->
         ram_ctl.raddr[IDX_W-1:0] == $past(ram_ctl.raddr[IDX_W-1:0]) + 1'b1)
      else $error("second tap is not the neighbour of the first");

   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POS) |-> (delay_ff >= DLY_MIN && delay_ff <= DLY_MAX))
      else $error("delay outside saturation range");
`endif

endmodule

// ===== test/twf_checker.sv =====
`timescale 1ns / 100ps
// checker for the tape wow/flutter delay: watches all three channels, predicts and compares
module twf_checker import twf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   twf_req_if       req_bus,
   twf_rsp_if       rsp_bus,
   twf_csr_if       csr_bus,
   output int       fail_count,
   output int       pending
);

   typedef struct {
      logic [CHIN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] sample;
   } audio_beat_type;

   audio_beat_type expected_beats[$];

   sine_tab_type sine_tab;
   logic [CNT_W-1:0]           channels_reg;
   logic [BASE_W-1:0]          base_reg;
   logic [DEPTH_W-1:0]         wow_depth_reg;
   logic [DEPTH_W-1:0]         flut_depth_reg;
   logic [PHASE_W-1:0]         wow_step_reg;
   logic [PHASE_W-1:0]         flut_step_reg;
   logic [COEFF_W-1:0]         tone_reg;
   logic signed [SAMPLE_W-1:0] tape [CHANNELS][DELAY_DEPTH];
   logic [IDX_W-1:0]           head;
   logic [PHASE_W-1:0]         wow_phase;
   logic [PHASE_W-1:0]         flut_phase;
   logic signed [TONE_W-1:0]   tone_acc [CHANNELS];

   // arithmetic shift on signed 64-bit is a floor division
   function automatic longint wobble(input logic [DEPTH_W-1:0] depth,
                                     input logic [PHASE_W-1:0] phase);
      logic [63:0] addr;
      longint      s;
      longint      mag;
      addr = (64'(phase) * SINE_ENTRIES) >> 32;
      s    = longint'(sine_tab[addr % SINE_ENTRIES]);
      mag  = (longint'(depth) * (s < 0 ? -s : s)) >>> 15;
      return s < 0 ? -mag : mag;
   endfunction

   task automatic predict_sample(input logic [CHIN_W-1:0] ch,
                                 input logic signed [SAMPLE_W-1:0] x);
      audio_beat_type e;
      int     count;
      longint dly, rp, d0, d1, y, st;
      int     i0, i1;
      longint frac;
      count = int'(channels_reg);
      if (count < 1) count = 1;
      if (count > CHANNELS) count = CHANNELS;
      e.channel = ch;
      e.sample  = '0;
      if (int'(ch) < count) begin
         tape[ch][head] = x;
         dly = longint'(base_reg) + wobble(wow_depth_reg, wow_phase)
             + wobble(flut_depth_reg, flut_phase);
         if (dly < 65536) dly = 65536;
         if (dly > longint'(DELAY_DEPTH - 2) * 65536) dly = longint'(DELAY_DEPTH - 2) * 65536;
         rp = longint'(head) * 65536 - dly;
         if (rp < 0) rp += longint'(DELAY_DEPTH) * 65536;
         i0   = int'((rp >>> 16) % DELAY_DEPTH);
         frac = rp & 64'hFFFF;
         i1   = (i0 + 1 >= DELAY_DEPTH) ? 0 : i0 + 1;
         d0   = longint'(tape[ch][i0]);
         d1   = longint'(tape[ch][i1]);
         y    = d0 + (((d1 - d0) * frac) >>> 16);
         st   = longint'(tone_acc[ch]);
         st   = st + (((y * 256 - st) * longint'(tone_reg)) >>> 16);
         tone_acc[ch] = TONE_W'(st);
         e.sample = SAMPLE_W'(longint'(tone_acc[ch]) >>> 8);
         if (int'(ch) == count - 1) begin
            wow_phase  += wow_step_reg;
            flut_phase += flut_step_reg;
            head       += 1'b1;
         end
      end
      expected_beats.push_back(e);
   endtask

   assign pending = expected_beats.size();

   initial sine_tab = build_sine();

   always @(posedge clock) begin
      audio_beat_type e;
      if (reset) begin
         channels_reg   <= CNT_W'(2);
         base_reg       <= BASE_W'(1048576);
         wow_depth_reg  <= '0;
         flut_depth_reg <= '0;
         wow_step_reg   <= '0;
         flut_step_reg  <= '0;
         tone_reg       <= '1;
         head           = '0;
         wow_phase      = '0;
         flut_phase     = '0;
         for (int c = 0; c < CHANNELS; c++) begin
            tone_acc[c] = '0;
            for (int k = 0; k < DELAY_DEPTH; k++) tape[c][k] = '0;
         end
         expected_beats.delete();
         fail_count <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_beats.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("mismatch: unexpected beat ch %0d sample %0d",
                           rsp_bus.channel_out, rsp_bus.sample_out);
            end else begin
               e = expected_beats.pop_front();
               if (e.channel !== rsp_bus.channel_out || e.sample !== rsp_bus.sample_out) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected ch %0d sample %0d, got ch %0d sample %0d",
                              e.channel, e.sample, rsp_bus.channel_out, rsp_bus.sample_out);
               end
            end
         end
         // requests predicted after the result check so a same-edge beat never pairs early
         if (req_bus.valid && req_bus.ready)
            predict_sample(req_bus.channel, req_bus.sample_in);
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_index_type'(csr_bus.index))
               CSR_CHANNELS:   channels_reg   <= CNT_W'(csr_bus.data);
               CSR_BASE:       base_reg       <= BASE_W'(csr_bus.data);
               CSR_WOW_DEPTH:  wow_depth_reg  <= DEPTH_W'(csr_bus.data);
               CSR_FLUT_DEPTH: flut_depth_reg <= DEPTH_W'(csr_bus.data);
               CSR_WOW_STEP:   wow_step_reg   <= csr_bus.data;
               CSR_FLUT_STEP:  flut_step_reg  <= csr_bus.data;
               CSR_TONE:       tone_reg       <= COEFF_W'(csr_bus.data);
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== test/tape_wow_flutter_delay_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench top: stimulus, register phases and verdict for the tape wow/flutter delay
module tape_wow_flutter_delay_unit_tb;
   import twf_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count;
   bit   hold_off;
   bit   quiet_rsp;

   twf_req_if req_bus ();
   twf_rsp_if rsp_bus ();
   twf_csr_if csr_bus ();

   tape_wow_flutter_delay_unit dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   twf_checker checker_i (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_bus(csr_bus), .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // receiver stalls; a long hold-off is counted here in cycles
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off) begin
         rsp_bus.ready <= 1'b0;
         repeat (400) @(posedge clock);
         hold_off = 1'b0;
      end else if (quiet_rsp) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         stall = gap_len();
         if (stall == 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= reset ? 0 : cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("FAIL tape_wow_flutter_delay_unit");
         $finish;
      end
   end

   task automatic send_sample(input logic [CHIN_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] x, input bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.channel   <= ch;
      req_bus.sample_in <= x;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // settle after the last checked beat; outside-frame beats are counted in pending too
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DAT_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_setting(input int phase);
      write_reg(CSR_CHANNELS, (phase % 4 == 3) ? 32'd0 : $urandom_range(0, 31));
      write_reg(CSR_BASE, (phase % 3 == 0) ? $urandom_range(65536, 4 << 16)
                                            : $urandom_range(0, 32'hFFFFFFF));
      write_reg(CSR_WOW_DEPTH, (phase % 2) ? $urandom_range(0, 32 << 16) : $urandom());
      write_reg(CSR_FLUT_DEPTH, $urandom_range(0, 16 << 16));
      write_reg(CSR_WOW_STEP, (phase == 2) ? 32'hFFFF_FFFF : $urandom());
      write_reg(CSR_FLUT_STEP, $urandom());
      write_reg(CSR_TONE, (phase == 1) ? 32'd0 : $urandom_range(0, 65535));
      // unknown index is ignored
      write_reg(csr_index_type'(3'd7), $urandom());
   endtask

   // mostly well-formed frames, some outside-frame and out-of-order channels
   task automatic random_frames(input int n, input bit gaps);
      int sent;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(0, 9) < 8) begin
            for (int c = 0; c < CHANNELS; c++) begin
               send_sample(CHIN_W'(c), SAMPLE_W'($urandom()), gaps);
               sent++;
            end
         end else begin
            send_sample(CHIN_W'($urandom_range(0, 15)), SAMPLE_W'($urandom()), gaps);
            sent++;
         end
      end
   endtask

   initial begin
      hold_off  = 1'b0;
      quiet_rsp = 1'b0;
      reset = 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.channel <= '0;
      req_bus.sample_in <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_CHANNELS;
      csr_bus.data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes with the reset channel count, short delays to see echoes
      write_reg(CSR_BASE, 32'd65536 + 32'h8000);
      write_reg(CSR_TONE, 32'hFFFF);
      send_sample(4'd0, 24'sh7FFFFF, 0);
      send_sample(4'd1, -24'sd8388608, 0);
      send_sample(4'd15, 24'sh7FFFFF, 0);
      send_sample(4'd2, -24'sd1, 0);
      for (int k = 0; k < 6; k++) begin
         send_sample(4'd0, (k % 2) ? -24'sd8388608 : 24'sh7FFFFF, 0);
         send_sample(4'd1, (k % 2) ? 24'sh555555 : -24'sh555556, 0);
      end
      send_sample(4'd1, 24'sd1, 0);
      drain();
      // saturation at both ends and one channel per frame
      write_reg(CSR_CHANNELS, 32'd1);
      write_reg(CSR_BASE, 32'hFFFFFFF);
      write_reg(CSR_WOW_DEPTH, 32'h7FFFFFF);
      write_reg(CSR_FLUT_DEPTH, 32'h7FFFFFF);
      write_reg(CSR_WOW_STEP, 32'h4000_0000);
      write_reg(CSR_FLUT_STEP, 32'hC000_0001);
      write_reg(CSR_TONE, 32'd1);
      for (int k = 0; k < 4; k++) send_sample(4'd0, SAMPLE_W'($urandom()), 0);
      send_sample(4'd1, 24'sd5, 0);
      drain();
      write_reg(CSR_CHANNELS, 32'd31);
      write_reg(CSR_BASE, 32'd0);
      write_reg(CSR_TONE, 32'd0);
      for (int k = 0; k < 4; k++) send_sample(CHIN_W'(k % 2), SAMPLE_W'($urandom()), 0);
      drain();

      // long receiver hold-off while samples keep coming
      hold_off = 1'b1;
      random_frames(40, 0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         random_setting(ph);
         quiet_rsp = (ph == 4);
         random_frames(100, ph != 5);
         drain();
      end
      quiet_rsp = 1'b0;

      if (fail_count == 0) begin
         $display("PASS tape_wow_flutter_delay_unit");
      end else begin
         $display("FAIL tape_wow_flutter_delay_unit");
      end
      $finish;
   end

endmodule
